// ===== rtl/ddawc_pkg.sv =====
// Shared types, constants and command codes of the DDA wall column caster.
`default_nettype none

package ddawc_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_MAP_SIZE  = 64;
  localparam int DEF_TEX_SIZE  = 64;
  localparam int DEF_MAX_STEPS = 128;

  // Field widths of the channels.
  localparam int COL_W   = 10;
  localparam int CELL_W  = 6;
  localparam int VAL_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd7;

  // Input operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // Datapath commands issued by the controller.
  typedef enum logic [4:0] {
    CMD_NOP, CMD_CLEAR, CMD_WRITE, CMD_LOAD,
    CMD_CAM_DIV, CMD_CAM_CAP, CMD_RX_MUL, CMD_RY_MUL, CMD_RY_CAP,
    CMD_DX_DIV, CMD_DX_CAP, CMD_DY_DIV, CMD_DY_CAP, CMD_INIT,
    CMD_SX_MUL, CMD_SY_MUL, CMD_SY_CAP, CMD_STEP, CMD_CHECK, CMD_PERP,
    CMD_LH_DIV, CMD_LH_CAP, CMD_TEX_MUL, CMD_TS_DIV, CMD_TS_CAP,
    CMD_TP_MUL, CMD_TP_CAP, CMD_OUT
  } ddawc_cmd_e;

  // Controller states.
  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_CAM_DIV, ST_CAM_WAIT, ST_RX_MUL, ST_RY_MUL, ST_RY_CAP,
    ST_DX_DIV, ST_DX_WAIT, ST_DY_DIV, ST_DY_WAIT, ST_INIT, ST_SX_MUL, ST_SY_MUL,
    ST_SY_CAP, ST_STEP, ST_CHECK, ST_PERP, ST_LH_DIV, ST_LH_WAIT, ST_TEX_MUL,
    ST_TS_DIV, ST_TS_WAIT, ST_TP_MUL, ST_TP_CAP, ST_DONE
  } ddawc_state_e;

  // Status returned from the datapath to the controller.
  typedef struct packed {
    logic op_cast;
    logic clear_last;
    logic div_done;
    logic start_oob;
    logic walk_oob;
    logic cell_hit;
    logic steps_done;
  } ddawc_status_t;

  // One result transaction.
  typedef struct packed {
    logic [COL_W-1:0] out_column;
    logic             hit_found;
    logic             hit_side;
    logic [15:0]      wall_distance;
    logic [15:0]      line_height;
    logic [9:0]       draw_start;
    logic [9:0]       draw_end;
    logic [3:0]       texture_index;
    logic [5:0]       texture_column;
    logic [21:0]      tex_step;
    logic [21:0]      tex_start;
  } ddawc_result_t;

endpackage

`default_nettype wire

// ===== rtl/ddawc_if.sv =====
// Channel interfaces: cast/write input, result output and configuration writes.
`default_nettype none

interface ddawc_in_if import ddawc_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              op;
  logic [COL_W-1:0]  column;
  logic [CELL_W-1:0] cell_x;
  logic [CELL_W-1:0] cell_y;
  logic [VAL_W-1:0]  cell_value;
  modport source (output valid, op, column, cell_x, cell_y, cell_value, input ready);
  modport sink   (input valid, op, column, cell_x, cell_y, cell_value, output ready);
endinterface

interface ddawc_out_if import ddawc_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] out_column;
  logic             hit_found;
  logic             hit_side;
  logic [15:0]      wall_distance;
  logic [15:0]      line_height;
  logic [9:0]       draw_start;
  logic [9:0]       draw_end;
  logic [3:0]       texture_index;
  logic [5:0]       texture_column;
  logic [21:0]      tex_step;
  logic [21:0]      tex_start;
  modport source (output valid, out_column, hit_found, hit_side, wall_distance,
                  line_height, draw_start, draw_end, texture_index, texture_column,
                  tex_step, tex_start, input ready);
  modport sink   (input valid, out_column, hit_found, hit_side, wall_distance,
                  line_height, draw_start, draw_end, texture_index, texture_column,
                  tex_step, tex_start, output ready);
endinterface

interface ddawc_cfg_if import ddawc_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ddawc_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit operands.
`default_nettype none

module ddawc_div import ddawc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic [32:0] shifted;
  logic        fits;

  // One shift-and-subtract step per cycle.
  always_comb begin
    shifted = {rem_q, quo_q[31]};
    fits    = shifted >= {1'b0, den_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? 32'(shifted - {1'b0, den_q}) : shifted[31:0];
      quo_d = {quo_q[30:0], fits};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

`ifndef NO_ASSERTIONS
  // A new division never starts on top of one in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider restarted while busy");
  // Completion follows the last iteration and ends the busy phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 5'd31 && !start_i) |=> (done_q && !busy_q))
    else $error("divider completion out of step");
`endif

endmodule

`default_nettype wire

// ===== rtl/ddawc_datapath.sv =====
// Datapath: camera registers, map memory, ray setup, DDA walk and slice math.
`default_nettype none

module ddawc_datapath import ddawc_pkg::*; #(
  parameter int MAP_SIZE  = DEF_MAP_SIZE,
  parameter int TEX_SIZE  = DEF_TEX_SIZE,
  parameter int MAX_STEPS = DEF_MAX_STEPS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ddawc_cmd_e           cmd_i,
  output ddawc_status_t        status_o,
  input  logic                 op_i,
  input  logic [COL_W-1:0]     column_i,
  input  logic [CELL_W-1:0]    cell_x_i,
  input  logic [CELL_W-1:0]    cell_y_i,
  input  logic [VAL_W-1:0]     cell_value_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output ddawc_result_t        result_o
);

  localparam int MAP_W  = $clog2(MAP_SIZE);
  localparam int MX_W   = MAP_W + 2;
  localparam int DEPTH  = MAP_SIZE * MAP_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NW     = $clog2(MAX_STEPS + 1);
  localparam int DIST_W = 41;
  localparam int SIDE_W = DIST_W + NW + 1;
  localparam int RAY_W  = 28;
  localparam int CAM_W  = 27;
  localparam int CAM_ONE = 16384;
  localparam int TS_NUM  = TEX_SIZE * 65536;
  localparam logic [21:0] TEXQ_MAX = 22'h3FFFFF;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [MAP_W-1:0] x,
                                                  input logic [MAP_W-1:0] y);
    return ADDR_W'(y) * ADDR_W'(MAP_SIZE) + ADDR_W'(x);
  endfunction

  // Camera registers.
  logic [15:0]        pos_x_q, pos_y_q;
  logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [10:0]        width_q, height_q;

  // Map memory.
  logic [VAL_W-1:0]  map_mem [DEPTH];
  logic [VAL_W-1:0]  rdata_q;
  logic [ADDR_W-1:0] clr_q;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              wr_in_map;

  // Working registers.
  logic [COL_W-1:0]        column_q;
  logic signed [CAM_W-1:0] cam_q;
  logic signed [RAY_W-1:0] rx_q, ry_q;
  logic [DIST_W-1:0]       dx_q, dy_q;
  logic signed [63:0]      prod_q;
  logic [SIDE_W-1:0]       sx_q, sy_q;
  logic signed [MX_W-1:0]  mx_q, my_q;
  logic                    side_q;
  logic [NW-1:0]           n_q;
  logic                    hit_q;
  logic [VAL_W-1:0]        cell_q;
  logic [31:0]             perp_q;
  logic [15:0]             lh_q;
  logic [21:0]             ts_q, tp_q;
  logic [9:0]              ds_q, de_q;
  logic [5:0]              tx_q;
  ddawc_result_t           res_q, res_d;

  // Shared divider and multiplier operands.
  logic               div_start, div_done;
  logic [31:0]        div_num, div_den, div_quo;
  logic signed [31:0] mul_a, mul_b;

  logic                    rx_neg, ry_neg;
  logic [RAY_W-1:0]        rx_abs, ry_abs;
  logic [10:0]             w_eff;
  logic [10:0]             fx, fy;
  logic [SIDE_W-1:0]       side_init;
  logic                    take_x;
  logic signed [MX_W-1:0]  mx_nx, my_nx;
  logic                    nx_in;
  logic [SIDE_W-1:0]       pdiff;
  logic [9:0]              h_half;
  logic [14:0]             lh_half, k_val;
  logic [15:0]             de_sum;
  logic [10:0]             h_less;
  logic [15:0]             frac;
  logic [31:0]             tmul;
  logic [15:0]             tcol;
  logic [15:0]             tcol_m;
  logic                    mirror;
  logic [29:0]             ray_other;

  assign rx_neg = rx_q[RAY_W-1];
  assign ry_neg = ry_q[RAY_W-1];
  assign rx_abs = rx_neg ? RAY_W'(-rx_q) : RAY_W'(rx_q);
  assign ry_abs = ry_neg ? RAY_W'(-ry_q) : RAY_W'(ry_q);
  assign w_eff  = (width_q == '0) ? 11'd1 : width_q;
  assign fx = rx_neg ? {1'b0, pos_x_q[9:0]} : 11'd1024 - {1'b0, pos_x_q[9:0]};
  assign fy = ry_neg ? {1'b0, pos_y_q[9:0]} : 11'd1024 - {1'b0, pos_y_q[9:0]};
  // Infinite delta is bit 40 alone, so the start distance becomes a shift.
  assign side_init = (cmd_i == CMD_SY_MUL)
                   ? (dx_q[DIST_W-1] ? SIDE_W'({fx, 30'b0}) : SIDE_W'(prod_q >>> 10))
                   : (dy_q[DIST_W-1] ? SIDE_W'({fy, 30'b0}) : SIDE_W'(prod_q >>> 10));

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      dir_x_q   <= -16'sd16384;
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= 16'sd10813;
      width_q   <= 11'd640;
      height_q  <= 11'd480;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_POS_X:   pos_x_q   <= cfg_data_i;
        REG_POS_Y:   pos_y_q   <= cfg_data_i;
        REG_DIR_X:   dir_x_q   <= signed'(cfg_data_i);
        REG_DIR_Y:   dir_y_q   <= signed'(cfg_data_i);
        REG_PLANE_X: plane_x_q <= signed'(cfg_data_i);
        REG_PLANE_Y: plane_y_q <= signed'(cfg_data_i);
        REG_WIDTH:   width_q   <= cfg_data_i[10:0];
        REG_HEIGHT:  height_q  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // Divider operand selection.
  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = '0;
    case (cmd_i)
      CMD_CAM_DIV: begin
        div_num = 32'({column_q, 15'b0});
        div_den = 32'(w_eff);
      end
      CMD_DX_DIV: begin
        div_num = 32'h4000_0000;
        div_den = 32'(rx_abs);
      end
      CMD_DY_DIV: begin
        div_num = 32'h4000_0000;
        div_den = 32'(ry_abs);
      end
      CMD_LH_DIV: begin
        div_num = 32'({height_q, 16'b0});
        div_den = perp_q;
      end
      CMD_TS_DIV: begin
        div_num = 32'(TS_NUM);
        div_den = 32'(lh_q);
      end
      default: div_start = 1'b0;
    endcase
  end

  ddawc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Multiplier operand selection.
  assign ray_other = side_q ? 30'(rx_q) : 30'(ry_q);
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i)
      CMD_RX_MUL: begin
        mul_a = 32'(plane_x_q);
        mul_b = 32'(cam_q);
      end
      CMD_RY_MUL: begin
        mul_a = 32'(plane_y_q);
        mul_b = 32'(cam_q);
      end
      CMD_SX_MUL: begin
        mul_a = signed'(32'(fx));
        mul_b = signed'(32'(dx_q[30:0]));
      end
      CMD_SY_MUL: begin
        mul_a = signed'(32'(fy));
        mul_b = signed'(32'(dy_q[30:0]));
      end
      CMD_TEX_MUL: begin
        mul_a = signed'({2'b0, perp_q[29:0]});
        mul_b = signed'({2'b0, ray_other});
      end
      CMD_TP_MUL: begin
        mul_a = signed'(32'(k_val));
        mul_b = signed'(32'(ts_q));
      end
      default: ;
    endcase
  end

  // DDA step: advance along the nearer grid line.
  assign take_x = sx_q < sy_q;
  assign mx_nx  = take_x ? mx_q + (rx_neg ? '1 : MX_W'(1)) : mx_q;
  assign my_nx  = take_x ? my_q : my_q + (ry_neg ? '1 : MX_W'(1));
  assign nx_in  = !mx_nx[MX_W-1] && (mx_nx < MX_W'(MAP_SIZE))
               && !my_nx[MX_W-1] && (my_nx < MX_W'(MAP_SIZE));
  assign rd_addr = nx_in ? cell_addr(mx_nx[MAP_W-1:0], my_nx[MAP_W-1:0]) : '0;

  // Cell write address.
  assign wr_in_map = (32'(cell_x_i) < MAP_SIZE) && (32'(cell_y_i) < MAP_SIZE);
  assign wr_addr   = cell_addr(MAP_W'(cell_x_i), MAP_W'(cell_y_i));

  // Map memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_CLEAR) begin
      map_mem[clr_q] <= '0;
    end else if (cmd_i == CMD_WRITE && wr_in_map) begin
      map_mem[wr_addr] <= cell_value_i;
    end
    if (cmd_i == CMD_STEP) begin
      rdata_q <= map_mem[rd_addr];
    end
  end

  // Slice geometry.
  assign pdiff   = side_q ? sy_q - SIDE_W'(dy_q) : sx_q - SIDE_W'(dx_q);
  assign h_half  = height_q[10:1];
  assign lh_half = lh_q[15:1];
  assign k_val   = (lh_half > 15'(h_half)) ? lh_half - 15'(h_half) : '0;
  assign de_sum  = 16'(lh_half) + 16'(h_half);
  assign h_less  = height_q - 11'd1;
  assign frac    = {side_q ? pos_x_q[9:0] : pos_y_q[9:0], 6'b0} + prod_q[29:14];
  assign tmul    = 32'(frac) * 32'(TEX_SIZE);
  assign tcol    = tmul[31:16];
  assign mirror  = (!side_q && !rx_neg && rx_q != '0) || (side_q && ry_neg);
  assign tcol_m  = mirror ? 16'(TEX_SIZE - 1) - tcol : tcol;

  // Result transaction assembled from the slice registers.
  always_comb begin
    res_d            = '0;
    res_d.out_column = column_q;
    if (hit_q) begin
      res_d.hit_found      = 1'b1;
      res_d.hit_side       = side_q;
      res_d.wall_distance  = (|perp_q[31:22]) ? 16'hFFFF : perp_q[21:6];
      res_d.line_height    = lh_q;
      res_d.draw_start     = ds_q;
      res_d.draw_end       = de_q;
      res_d.texture_index  = cell_q - 4'd1;
      res_d.texture_column = tx_q;
      res_d.tex_step       = ts_q;
      res_d.tex_start      = tp_q;
    end
  end

  // Working registers, advanced by command.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD:    column_q <= column_i;
      CMD_CAM_CAP: cam_q <= CAM_W'(div_quo) - CAM_W'(CAM_ONE);
      CMD_RX_MUL:  prod_q <= mul_a * mul_b;
      CMD_RY_MUL: begin
        rx_q   <= RAY_W'(dir_x_q) + RAY_W'(prod_q >>> 14);
        prod_q <= mul_a * mul_b;
      end
      CMD_RY_CAP:  ry_q <= RAY_W'(dir_y_q) + RAY_W'(prod_q >>> 14);
      CMD_DX_CAP:  dx_q <= (rx_q == '0) ? DIST_W'(1) << 40 : DIST_W'(div_quo);
      CMD_DY_CAP:  dy_q <= (ry_q == '0) ? DIST_W'(1) << 40 : DIST_W'(div_quo);
      CMD_INIT: begin
        mx_q <= MX_W'(pos_x_q[15:10]);
        my_q <= MX_W'(pos_y_q[15:10]);
      end
      CMD_SX_MUL:  prod_q <= mul_a * mul_b;
      CMD_SY_MUL: begin
        sx_q   <= side_init;
        prod_q <= mul_a * mul_b;
      end
      CMD_SY_CAP:  sy_q <= side_init;
      CMD_STEP: begin
        mx_q   <= mx_nx;
        my_q   <= my_nx;
        side_q <= !take_x;
        if (take_x) begin
          sx_q <= sx_q + SIDE_W'(dx_q);
        end else begin
          sy_q <= sy_q + SIDE_W'(dy_q);
        end
      end
      CMD_CHECK:   cell_q <= rdata_q;
      CMD_PERP:    perp_q <= (|pdiff[SIDE_W-1:32]) ? '1 : pdiff[31:0];
      CMD_LH_CAP: begin
        if (perp_q == '0 || |div_quo[31:16]) begin
          lh_q <= '1;
        end else begin
          lh_q <= div_quo[15:0];
        end
      end
      CMD_TEX_MUL: prod_q <= mul_a * mul_b;
      CMD_TS_DIV: begin
        ds_q <= (15'(h_half) > lh_half) ? h_half - 10'(lh_half) : '0;
        if (height_q == '0) begin
          de_q <= '0;
        end else if (de_sum >= 16'(h_less)) begin
          de_q <= (h_less > 11'd1023) ? 10'd1023 : h_less[9:0];
        end else begin
          de_q <= (de_sum > 16'd1023) ? 10'd1023 : de_sum[9:0];
        end
        tx_q <= tcol_m[5:0];
      end
      CMD_TS_CAP: ts_q <= (lh_q == '0 || |div_quo[31:22]) ? TEXQ_MAX : div_quo[21:0];
      CMD_TP_MUL: prod_q <= mul_a * mul_b;
      CMD_TP_CAP: tp_q <= (|prod_q[63:22]) ? TEXQ_MAX : prod_q[21:0];
      CMD_OUT:    res_q <= res_d;
      default: ;
    endcase
  end

  // Control state: clearing sweep, step count and hit flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      n_q   <= '0;
      hit_q <= 1'b0;
    end else begin
      if (cmd_i == CMD_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cmd_i == CMD_LOAD) begin
        hit_q <= 1'b0;
        n_q   <= '0;
      end else if (cmd_i == CMD_STEP) begin
        n_q <= n_q + NW'(1);
      end else if (cmd_i == CMD_CHECK && !status_o.walk_oob && rdata_q != '0) begin
        hit_q <= 1'b1;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    status_o.op_cast    = (op_i == OP_CAST);
    status_o.clear_last = (clr_q == ADDR_W'(DEPTH - 1));
    status_o.div_done   = div_done;
    status_o.start_oob  = (32'(pos_x_q[15:10]) >= MAP_SIZE)
                       || (32'(pos_y_q[15:10]) >= MAP_SIZE);
    status_o.walk_oob   = mx_q[MX_W-1] || (mx_q >= MX_W'(MAP_SIZE))
                       || my_q[MX_W-1] || (my_q >= MX_W'(MAP_SIZE));
    status_o.cell_hit   = (rdata_q != '0);
    status_o.steps_done = (n_q == NW'(MAX_STEPS));
  end

  assign result_o = res_q;

`ifndef NO_ASSERTIONS
  // The walk never runs past its step limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= NW'(MAX_STEPS))
    else $error("step count beyond limit");
  // A slice is only computed for a ray that found a wall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_PERP) |-> hit_q)
    else $error("slice computed without a hit");
`endif

endmodule

`default_nettype wire

// ===== rtl/ddawc_ctrl.sv =====
// Controller state machine: sequences the map clear, cell writes and casts.
`default_nettype none

module ddawc_ctrl import ddawc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ddawc_status_t status_i,
  output ddawc_cmd_e    cmd_o
);

  ddawc_state_e state_q, state_d;
  logic         out_valid_q, out_valid_d;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NOP;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_CLEAR: begin
        cmd_o = CMD_CLEAR;
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (status_i.op_cast) begin
            cmd_o   = CMD_LOAD;
            state_d = ST_CAM_DIV;
          end else begin
            cmd_o = CMD_WRITE;
          end
        end
      end
      ST_CAM_DIV: begin
        cmd_o   = CMD_CAM_DIV;
        state_d = ST_CAM_WAIT;
      end
      ST_CAM_WAIT: begin
        if (status_i.div_done) begin
          cmd_o   = CMD_CAM_CAP;
          state_d = ST_RX_MUL;
        end
      end
      ST_RX_MUL: begin
        cmd_o   = CMD_RX_MUL;
        state_d = ST_RY_MUL;
      end
      ST_RY_MUL: begin
        cmd_o   = CMD_RY_MUL;
        state_d = ST_RY_CAP;
      end
      ST_RY_CAP: begin
        cmd_o   = CMD_RY_CAP;
        state_d = ST_DX_DIV;
      end
      ST_DX_DIV: begin
        cmd_o   = CMD_DX_DIV;
        state_d = ST_DX_WAIT;
      end
      ST_DX_WAIT: begin
        if (status_i.div_done) begin
          cmd_o   = CMD_DX_CAP;
          state_d = ST_DY_DIV;
        end
      end
      ST_DY_DIV: begin
        cmd_o   = CMD_DY_DIV;
        state_d = ST_DY_WAIT;
      end
      ST_DY_WAIT: begin
        if (status_i.div_done) begin
          cmd_o   = CMD_DY_CAP;
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o   = CMD_INIT;
        state_d = status_i.start_oob ? ST_DONE : ST_SX_MUL;
      end
      ST_SX_MUL: begin
        cmd_o   = CMD_SX_MUL;
        state_d = ST_SY_MUL;
      end
      ST_SY_MUL: begin
        cmd_o   = CMD_SY_MUL;
        state_d = ST_SY_CAP;
      end
      ST_SY_CAP: begin
        cmd_o   = CMD_SY_CAP;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        cmd_o   = CMD_STEP;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o = CMD_CHECK;
        if (status_i.walk_oob) begin
          state_d = ST_DONE;
        end else if (status_i.cell_hit) begin
          state_d = ST_PERP;
        end else if (status_i.steps_done) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_PERP: begin
        cmd_o   = CMD_PERP;
        state_d = ST_LH_DIV;
      end
      ST_LH_DIV: begin
        cmd_o   = CMD_LH_DIV;
        state_d = ST_LH_WAIT;
      end
      ST_LH_WAIT: begin
        if (status_i.div_done) begin
          cmd_o   = CMD_LH_CAP;
          state_d = ST_TEX_MUL;
        end
      end
      ST_TEX_MUL: begin
        cmd_o   = CMD_TEX_MUL;
        state_d = ST_TS_DIV;
      end
      ST_TS_DIV: begin
        cmd_o   = CMD_TS_DIV;
        state_d = ST_TS_WAIT;
      end
      ST_TS_WAIT: begin
        if (status_i.div_done) begin
          cmd_o   = CMD_TS_CAP;
          state_d = ST_TP_MUL;
        end
      end
      ST_TP_MUL: begin
        cmd_o   = CMD_TP_MUL;
        state_d = ST_TP_CAP;
      end
      ST_TP_CAP: begin
        cmd_o   = CMD_TP_CAP;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = CMD_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // A finished cast with a free output register returns to idle at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_valid_q) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("finished cast not delivered");
`endif

endmodule

`default_nettype wire

// ===== rtl/dda_wall_column_caster.sv =====
// Top level of the DDA wall column caster: controller, datapath and channel wiring.
//
//   channel     dir  transaction
//   in_chan_i   in   op 0 writes one map cell, op 1 casts one screen column
//   res_chan_o  out  one wall slice result per cast
//   cfg_chan_i  in   camera and screen register write (index, data), always ready
//
// A cell write is done at the edge that accepts it. A cast keeps the input from taking
// the next item until it is done, walking at most MAX_STEPS map cells. Five 32-bit
// divisions at one quotient bit per cycle (camera offset, two ray deltas, line height,
// texture step) serve a hit; a miss skips the last two and finishes sooner. After
// reset the map memory, MAP_SIZE*MAP_SIZE cells (4096 by default), is cleared while no
// input is accepted. A waiting result does not block the next input; a finished cast
// holds until the output register is free.
`default_nettype none

module dda_wall_column_caster import ddawc_pkg::*; #(
  parameter int MAP_SIZE  = DEF_MAP_SIZE,
  parameter int TEX_SIZE  = DEF_TEX_SIZE,
  parameter int MAX_STEPS = DEF_MAX_STEPS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ddawc_in_if.sink    in_chan_i,
  ddawc_out_if.source res_chan_o,
  ddawc_cfg_if.sink   cfg_chan_i
);

  ddawc_cmd_e    cmd;
  ddawc_status_t status;
  ddawc_result_t result;

  assign cfg_chan_i.ready = 1'b1;

  ddawc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan_i.valid),
    .in_ready_o  (in_chan_i.ready),
    .out_valid_o (res_chan_o.valid),
    .out_ready_i (res_chan_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ddawc_datapath #(
    .MAP_SIZE  (MAP_SIZE),
    .TEX_SIZE  (TEX_SIZE),
    .MAX_STEPS (MAX_STEPS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .op_i         (in_chan_i.op),
    .column_i     (in_chan_i.column),
    .cell_x_i     (in_chan_i.cell_x),
    .cell_y_i     (in_chan_i.cell_y),
    .cell_value_i (in_chan_i.cell_value),
    .cfg_we_i     (cfg_chan_i.valid),
    .cfg_index_i  (cfg_chan_i.index),
    .cfg_data_i   (cfg_chan_i.data),
    .result_o     (result)
  );

  // Result payload onto the output channel.
  assign res_chan_o.out_column     = result.out_column;
  assign res_chan_o.hit_found      = result.hit_found;
  assign res_chan_o.hit_side       = result.hit_side;
  assign res_chan_o.wall_distance  = result.wall_distance;
  assign res_chan_o.line_height    = result.line_height;
  assign res_chan_o.draw_start     = result.draw_start;
  assign res_chan_o.draw_end       = result.draw_end;
  assign res_chan_o.texture_index  = result.texture_index;
  assign res_chan_o.texture_column = result.texture_column;
  assign res_chan_o.tex_step       = result.tex_step;
  assign res_chan_o.tex_start      = result.tex_start;

endmodule

`default_nettype wire

// ===== bench/ddawc_checker.sv =====
// Scoreboard of the wall column caster: watches all channels, predicts each slice and compares.
module ddawc_checker import ddawc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  ddawc_in_if   in_chan,
  ddawc_out_if  res_chan,
  ddawc_cfg_if  cfg_chan,
  output int    fail_count_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PERP_CAP = 64'hFFFF_FFFF;
  localparam longint TEXQ_CAP = 4194303;

  // Shadow copy of the camera registers and of the map.
  logic        [15:0] cam_pos_x, cam_pos_y;
  logic signed [15:0] cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
  logic        [10:0] scr_w, scr_h;
  logic        [3:0]  grid[DEF_MAP_SIZE*DEF_MAP_SIZE];
  ddawc_result_t      slice_q[$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = slice_q.size();

  function automatic longint clamp(input longint v, input longint hi);
    if (v < 0) return 0;
    return (v > hi) ? hi : v;
  endfunction

  // Distance along the ray between two grid lines, Q.16.
  function automatic longint grid_delta(input longint r);
    if (r == 0) return longint'(1) << 40;
    return (longint'(1) << 30) / ((r < 0) ? -r : r);
  endfunction

  // Walk the map for one screen column and build the expected slice.
  function automatic ddawc_result_t cast_column(input logic [COL_W-1:0] col);
    longint w, h, cam, rx, ry, dx, dy, sx, sy, mx, my;
    longint perp, lh, ds, de, ts, tp, hitp, tx;
    int side, wall_val;
    bit found;
    ddawc_result_t r;
    r = '0;
    r.out_column = col;
    side = 0;
    wall_val = 0;
    found = 0;
    w = (scr_w == 0) ? 1 : longint'(scr_w);
    h = longint'(scr_h);
    cam = (2 * longint'(col) * 16384) / w - 16384;
    rx = longint'(cam_dir_x) + ((longint'(cam_plane_x) * cam) >>> 14);
    ry = longint'(cam_dir_y) + ((longint'(cam_plane_y) * cam) >>> 14);
    dx = grid_delta(rx);
    dy = grid_delta(ry);
    mx = longint'(cam_pos_x >> 10);
    my = longint'(cam_pos_y >> 10);
    if (mx >= DEF_MAP_SIZE || my >= DEF_MAP_SIZE) return r;
    sx = (rx < 0) ? ((longint'(cam_pos_x[9:0]) * dx) >> 10)
                  : (((1024 - longint'(cam_pos_x[9:0])) * dx) >> 10);
    sy = (ry < 0) ? ((longint'(cam_pos_y[9:0]) * dy) >> 10)
                  : (((1024 - longint'(cam_pos_y[9:0])) * dy) >> 10);
    for (int n = 0; n < DEF_MAX_STEPS; n++) begin
      if (sx < sy) begin
        sx += dx;
        mx += (rx < 0) ? -1 : 1;
        side = 0;
      end else begin
        sy += dy;
        my += (ry < 0) ? -1 : 1;
        side = 1;
      end
      if (mx < 0 || mx >= DEF_MAP_SIZE || my < 0 || my >= DEF_MAP_SIZE) return r;
      wall_val = grid[my * DEF_MAP_SIZE + mx];
      if (wall_val > 0) begin
        found = 1;
        break;
      end
    end
    if (!found) return r;

    // Slice geometry.
    perp = clamp(side ? sy - dy : sx - dx, PERP_CAP);
    lh = (perp == 0) ? 65535 : clamp((h << 16) / perp, 65535);
    ds = h / 2 - lh / 2;
    if (ds < 0) ds = 0;
    de = lh / 2 + h / 2;
    if (de > h - 1) de = h - 1;
    if (de < 0) de = 0;

    // Texture coordinates.
    if (side == 0) hitp = (longint'(cam_pos_y) << 6) + ((perp * ry) >>> 14);
    else           hitp = (longint'(cam_pos_x) << 6) + ((perp * rx) >>> 14);
    tx = ((hitp & 64'hFFFF) * DEF_TEX_SIZE) >> 16;
    if ((side == 0 && rx > 0) || (side == 1 && ry < 0)) tx = DEF_TEX_SIZE - 1 - tx;
    ts = (lh == 0) ? TEXQ_CAP : clamp((longint'(DEF_TEX_SIZE) << 16) / lh, TEXQ_CAP);
    tp = clamp((ds - h / 2 + lh / 2) * ts, TEXQ_CAP);

    r.hit_found      = 1'b1;
    r.hit_side       = side[0];
    r.wall_distance  = 16'(clamp(perp >> 6, 65535));
    r.line_height    = 16'(lh);
    r.draw_start     = 10'(clamp(ds, 1023));
    r.draw_end       = 10'(clamp(de, 1023));
    r.texture_index  = 4'(wall_val - 1);
    r.texture_column = 6'(tx);
    r.tex_step       = 22'(ts);
    r.tex_start      = 22'(tp);
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  // Track every transaction on the three channels.
  always @(posedge clk_i or negedge rst_ni) begin
    ddawc_result_t want, got;
    if (!rst_ni) begin
      cam_pos_x   <= '0;
      cam_pos_y   <= '0;
      cam_dir_x   <= -16'sd16384;
      cam_dir_y   <= '0;
      cam_plane_x <= '0;
      cam_plane_y <= 16'sd10813;
      scr_w       <= 11'd640;
      scr_h       <= 11'd480;
      for (int i = 0; i < DEF_MAP_SIZE * DEF_MAP_SIZE; i++) grid[i] = '0;
      slice_q.delete();
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          REG_POS_X:   cam_pos_x   <= cfg_chan.data;
          REG_POS_Y:   cam_pos_y   <= cfg_chan.data;
          REG_DIR_X:   cam_dir_x   <= cfg_chan.data;
          REG_DIR_Y:   cam_dir_y   <= cfg_chan.data;
          REG_PLANE_X: cam_plane_x <= cfg_chan.data;
          REG_PLANE_Y: cam_plane_y <= cfg_chan.data;
          REG_WIDTH:   scr_w       <= cfg_chan.data[10:0];
          REG_HEIGHT:  scr_h       <= cfg_chan.data[10:0];
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        if (in_chan.op == OP_WRITE) grid[{in_chan.cell_y, in_chan.cell_x}] = in_chan.cell_value;
        else slice_q.insert(slice_q.size(), cast_column(in_chan.column));
      end
      if (res_chan.valid && res_chan.ready) begin
        got = '{res_chan.out_column, res_chan.hit_found, res_chan.hit_side,
                res_chan.wall_distance, res_chan.line_height, res_chan.draw_start,
                res_chan.draw_end, res_chan.texture_index, res_chan.texture_column,
                res_chan.tex_step, res_chan.tex_start};
        if (slice_q.size() == 0) begin
          $error("slice result for column %0d with no cast waiting", got.out_column);
          fails++;
        end else begin
          want = slice_q.pop_front();
          check_field("out_column", want.out_column, got.out_column);
          check_field("hit_found", want.hit_found, got.hit_found);
          check_field("hit_side", want.hit_side, got.hit_side);
          check_field("wall_distance", want.wall_distance, got.wall_distance);
          check_field("line_height", want.line_height, got.line_height);
          check_field("draw_start", want.draw_start, got.draw_start);
          check_field("draw_end", want.draw_end, got.draw_end);
          check_field("texture_index", want.texture_index, got.texture_index);
          check_field("texture_column", want.texture_column, got.texture_column);
          check_field("tex_step", want.tex_step, got.tex_step);
          check_field("tex_start", want.tex_start, got.tex_start);
        end
      end
    end
  end

endmodule

// ===== bench/tb_dda_wall_column_caster.sv =====
// Testbench top of the wall column caster: clock, reset, stimulus, flow control and verdict.
module tb_dda_wall_column_caster;
  import ddawc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int ITEM_GOAL   = 800;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_request = 0;
  int   items_sent = 0;
  int   cycles = 0;

  ddawc_in_if  in_if();
  ddawc_out_if res_if();
  ddawc_cfg_if cfg_if();

  dda_wall_column_caster u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .res_chan_o (res_if),
    .cfg_chan_i (cfg_if)
  );

  ddawc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_chan      (in_if),
    .res_chan     (res_if),
    .cfg_chan     (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left = 3000;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic op, input logic [COL_W-1:0] col,
                           input logic [CELL_W-1:0] cx, input logic [CELL_W-1:0] cy,
                           input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid      <= 1'b1;
    in_if.op         <= op;
    in_if.column     <= col;
    in_if.cell_x     <= cx;
    in_if.cell_y     <= cy;
    in_if.cell_value <= val;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic cast(input logic [COL_W-1:0] col);
    send_item(OP_CAST, col, 6'($urandom), 6'($urandom), 4'($urandom));
  endtask

  task automatic put_cell(input int cx, input int cy, input int val);
    send_item(OP_WRITE, 10'($urandom), 6'(cx), 6'(cy), 4'(val));
  endtask

  // Let every cast finish before touching the camera registers.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_camera(input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] dx, input logic [15:0] dy,
                            input logic [15:0] plx, input logic [15:0] ply,
                            input logic [15:0] w, input logic [15:0] h);
    write_reg(REG_POS_X, px);
    write_reg(REG_POS_Y, py);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_PLANE_X, plx);
    write_reg(REG_PLANE_Y, ply);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // Signed Q2.14 vector component, extremes now and then.
  function automatic logic [15:0] pick_vec();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(32767));
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic [15:0] pick_size(input int lo);
    case ($urandom_range(9))
      0: return 16'(lo);
      1: return 16'd1024;
      2: return 16'h07FF;
      3: return 16'($urandom);
      4: return 16'd0;
      default: return 16'($urandom_range(1024, lo));
    endcase
  endfunction

  initial begin
    int x0, y0, x1, y1, px, py, n_cast, w_cols;
    logic [15:0] w_reg;
    in_if.valid = 1'b0;
    in_if.op = OP_WRITE;
    in_if.column = '0;
    in_if.cell_x = '0;
    in_if.cell_y = '0;
    in_if.cell_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_POS_X;
    cfg_if.data = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset camera at the map corner, ray leaves the map at once.
    cast(10'd0);
    put_cell(0, 0, 15);
    put_cell(63, 63, 1);
    put_cell(1, 2, 7);
    put_cell(5, 5, 0);
    cast(10'd1023);
    drain();
    // Camera on a grid line facing a wall in the adjacent cell: zero distance.
    set_camera(16'(2 << 10), 16'(2 << 10) + 16'd512, 16'hC000, 16'h0000,
               16'h0000, 16'h0000, 16'd640, 16'd480);
    cast(10'd0);
    cast(10'd320);
    drain();
    // Far wall with a tiny screen: zero line height; zero screen width.
    set_camera(16'(10 << 10) + 16'd512, 16'(2 << 10) + 16'd512, 16'hC000, 16'h0000,
               16'h0000, 16'h2A3D, 16'd0, 16'd2);
    cast(10'd0);
    cast(10'd1023);
    drain();
    // Extreme camera positions and screen sizes.
    set_camera(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
               16'd1024, 16'h07FF);
    cast(10'd0);
    cast(10'd512);
    drain();
    set_camera(16'h0000, 16'h0000, 16'h4000, 16'h4000, 16'h8000, 16'h7FFF,
               16'd1, 16'd1024);
    cast(10'd0);
    cast(10'd1023);

    // Random scenes: mostly a walled room around the camera, then a burst of casts.
    for (int phase = 0; items_sent < ITEM_GOAL; phase++) begin
      drain();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      x0 = $urandom_range(55);
      y0 = $urandom_range(55);
      x1 = x0 + $urandom_range(8, 2);
      y1 = y0 + $urandom_range(8, 2);
      px = $urandom_range(x1 - 1, x0 + 1);
      py = $urandom_range(y1 - 1, y0 + 1);
      w_reg = pick_size(1);
      w_cols = (w_reg[10:0] == 0) ? 1 : int'(w_reg[10:0]);
      if ($urandom_range(7) == 0)
        set_camera(16'($urandom), 16'($urandom), pick_vec(), pick_vec(), pick_vec(),
                   pick_vec(), w_reg, pick_size(2));
      else
        set_camera(16'((px << 10) + $urandom_range(1023)),
                   16'((py << 10) + $urandom_range(1023)),
                   pick_vec(), pick_vec(), pick_vec(), pick_vec(), w_reg, pick_size(2));
      if ($urandom_range(5) != 0) begin
        for (int i = x0; i <= x1; i++) begin
          put_cell(i, y0, $urandom_range(15, 1));
          put_cell(i, y1, $urandom_range(15, 1));
        end
        for (int j = y0 + 1; j < y1; j++) begin
          put_cell(x0, j, $urandom_range(15, 1));
          put_cell(x1, j, $urandom_range(15, 1));
        end
      end
      // Stray cells, empty ones included, mixed with the casts.
      n_cast = $urandom_range(24, 8);
      for (int k = 0; k < n_cast; k++) begin
        if ($urandom_range(5) == 0)
          put_cell($urandom_range(63), $urandom_range(63), $urandom_range(15));
        if ($urandom_range(7) == 0) cast(10'($urandom));
        else cast(10'($urandom_range((w_cols > 1024 ? 1024 : w_cols) - 1)));
        if (phase == 2 && k == 1) hold_request = 1;
      end
    end

    drain();
    repeat (600) @(posedge clk_i);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
